>>> hw/rtl/sct_pkg.sv
// sct_pkg: shared types, fixed-point constants and the reciprocal table
// for the sine/cosine taylor unit. no dependencies.
package sct_pkg;

    localparam int TERMS_DEFAULT = 10;

    localparam int ANGLE_W     = 32;
    localparam int VALUE_W     = 32;
    localparam int IN_SHIFT    = 16;   // q7.24 -> q8.40
    localparam int FRAC        = 40;
    localparam int MAG_W       = 48;
    localparam int XW          = 50;   // signed working width
    localparam int DIG_W       = 24;   // multiplier digit
    localparam int ACC_W       = 97;   // product accumulator
    localparam int OUT_SHIFT   = 10;   // q8.40 -> q2.30
    localparam int Q_W         = MAG_W + 1 - OUT_SHIFT;
    localparam int STEP_W      = 3;
    localparam int RECIP_IDX_W = 4;
    localparam int WRAP_SHIFT  = 5;
    localparam int REDUCE_TOP  = 5;
    localparam int PP_LAST     = 3;

    localparam logic [XW-1:0]    TWO_PI_Q  = 50'h6487ED5110B;
    localparam logic [XW-1:0]    HALF_PI_Q = 50'h1921FB54443;
    localparam logic [XW-1:0]    WRAP_Q    = TWO_PI_Q << WRAP_SHIFT;
    localparam logic [MAG_W-1:0] MAG_MAX   = {MAG_W{1'b1}};
    localparam logic [Q_W-1:0]   ONE_OUT   = Q_W'(1) << (FRAC - OUT_SHIFT + 0 - 10 + 10 - 0);
    localparam logic [ACC_W-1:0] MUL_ROUND = ACC_W'(1) << (FRAC - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_REDUCE,
        S_MSETUP,
        S_MSTEP,
        S_MWB,
        S_ACCUM,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_XSQ,
        MUL_RECIP
    } mul_sel_t;

    typedef struct packed {
        logic                   load;
        logic                   wrap;
        logic                   reduce;
        logic                   mul_setup;
        logic                   mul_step;
        logic                   mul_wb;
        logic                   accum;
        logic                   finish;
        mul_sel_t               sel;
        logic [STEP_W-1:0]      step;
        logic [RECIP_IDX_W-1:0] term_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic x_neg;
    } dp_status_t;

    // round(2^40 / (n*(n-1))) for n = 2*idx + 3, halves up
    function automatic logic [MAG_W-1:0] recip_q40(input logic [RECIP_IDX_W-1:0] idx);
        logic [MAG_W-1:0] r;
        case (idx)
            4'd0:    r = 48'd183251937963;
            4'd1:    r = 48'd54975581389;
            4'd2:    r = 48'd26178848280;
            4'd3:    r = 48'd15270994830;
            4'd4:    r = 48'd9995560253;
            4'd5:    r = 48'd7048151460;
            4'd6:    r = 48'd5235769656;
            4'd7:    r = 48'd4042322161;
            4'd8:    r = 48'd3214946280;
            4'd9:    r = 48'd2617884828;
            4'd10:   r = 48'd2172947881;
            4'd11:   r = 48'd1832519380;
            4'd12:   r = 48'd1566255880;
            4'd13:   r = 48'd1354078359;
            4'd14:   r = 48'd1182270568;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/sct_datapath.sv
// sct_datapath: angle reduction, shared 24x24 multiplier with product
// accumulator, series sum and output rounding. depends on sct_pkg.
module sct_datapath (
    input  logic                  aclk,
    input  sct_pkg::dp_cmd_t      cmd,
    output sct_pkg::dp_status_t   status,
    input  logic                  in_kind,
    input  logic [31:0]           in_angle,
    output logic [31:0]           value
);
    import sct_pkg::*;

    localparam logic signed [XW-1:0] MAG_MAX_S = signed'(XW'(MAG_MAX));

    logic [XW-1:0]           x_reg, x_next;
    logic [MAG_W-1:0]        xsq_reg, xsq_next;
    logic [MAG_W-1:0]        term_mag_reg, term_mag_next;
    logic                    term_neg_reg, term_neg_next;
    logic signed [XW-1:0]    sum_reg, sum_next;
    logic [MAG_W-1:0]        mul_a_reg, mul_a_next;
    logic [MAG_W-1:0]        mul_b_reg, mul_b_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [VALUE_W-1:0]      value_reg, value_next;

    logic signed [XW-1:0]    ang_ext;
    logic [XW-1:0]           x_in;
    logic [XW-1:0]           red_div;
    logic [DIG_W-1:0]        dig_a, dig_b;
    logic [2*DIG_W-1:0]      pp;
    logic [1:0]              pp_pos;
    logic [MAG_W-1:0]        mul_res;
    logic signed [XW-1:0]    term_s, sum_s;
    logic [MAG_W-1:0]        sum_abs;
    logic [MAG_W:0]          q_full;
    logic [Q_W-1:0]          q, q_sat;

    assign ang_ext = XW'(signed'(in_angle)) <<< IN_SHIFT;
    assign x_in    = in_kind ? (HALF_PI_Q - XW'(ang_ext)) : XW'(ang_ext);
    assign red_div = TWO_PI_Q << cmd.step;

    assign dig_a   = cmd.step[0] ? mul_a_reg[2*DIG_W-1:DIG_W] : mul_a_reg[DIG_W-1:0];
    assign dig_b   = cmd.step[1] ? mul_b_reg[2*DIG_W-1:DIG_W] : mul_b_reg[DIG_W-1:0];
    assign pp      = dig_a * dig_b;
    assign pp_pos  = {1'b0, cmd.step[0]} + {1'b0, cmd.step[1]};
    assign mul_res = (|acc_reg[ACC_W-1:FRAC+MAG_W]) ? MAG_MAX : acc_reg[FRAC+MAG_W-1:FRAC];

    assign term_s  = term_neg_reg ? -signed'(XW'(term_mag_reg)) : signed'(XW'(term_mag_reg));
    assign sum_s   = sum_reg + term_s;

    assign sum_abs = sum_reg[XW-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
    assign q_full  = {1'b0, sum_abs} + (MAG_W+1)'(1 << (OUT_SHIFT - 1));
    assign q       = q_full[MAG_W:OUT_SHIFT];
    assign q_sat   = (q > ONE_OUT) ? ONE_OUT : q;

    always_comb begin
        x_next        = x_reg;
        xsq_next      = xsq_reg;
        term_mag_next = term_mag_reg;
        term_neg_next = term_neg_reg;
        sum_next      = sum_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        acc_next      = acc_reg;
        value_next    = value_reg;
        if (cmd.load) begin
            x_next = x_in;
        end
        if (cmd.wrap) begin
            x_next = x_reg + WRAP_Q;
        end
        if (cmd.reduce && (x_reg >= red_div)) begin
            x_next = x_reg - red_div;
        end
        if (cmd.mul_setup) begin
            acc_next = MUL_ROUND;
            case (cmd.sel)
                MUL_SQ: begin
                    mul_a_next = x_reg[MAG_W-1:0];
                    mul_b_next = x_reg[MAG_W-1:0];
                end
                MUL_XSQ: begin
                    mul_a_next = term_mag_reg;
                    mul_b_next = xsq_reg;
                end
                MUL_RECIP: begin
                    mul_a_next = term_mag_reg;
                    mul_b_next = recip_q40(cmd.term_idx);
                end
                default: begin
                    mul_a_next = '0;
                    mul_b_next = '0;
                end
            endcase
        end
        if (cmd.mul_step) begin
            acc_next = acc_reg + (ACC_W'(pp) << (DIG_W * pp_pos));
        end
        if (cmd.mul_wb) begin
            case (cmd.sel)
                MUL_SQ: begin
                    xsq_next      = mul_res;
                    term_mag_next = x_reg[MAG_W-1:0];
                    term_neg_next = 1'b0;
                    sum_next      = '0;
                end
                MUL_XSQ: begin
                    term_mag_next = mul_res;
                end
                MUL_RECIP: begin
                    term_mag_next = mul_res;
                    term_neg_next = ~term_neg_reg;
                end
                default: begin
                    term_mag_next = term_mag_reg;
                end
            endcase
        end
        if (cmd.accum) begin
            if (sum_s > MAG_MAX_S) begin
                sum_next = MAG_MAX_S;
            end else if (sum_s < -MAG_MAX_S) begin
                sum_next = -MAG_MAX_S;
            end else begin
                sum_next = sum_s;
            end
        end
        if (cmd.finish) begin
            value_next = sum_reg[XW-1] ? -VALUE_W'(q_sat) : VALUE_W'(q_sat);
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        xsq_reg      <= xsq_next;
        term_mag_reg <= term_mag_next;
        term_neg_reg <= term_neg_next;
        sum_reg      <= sum_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        acc_reg      <= acc_next;
        value_reg    <= value_next;
    end

    assign status.x_neg = x_reg[XW-1];
    assign value        = value_reg;

`ifndef NO_ASSERTIONS
    // reduction must leave the angle in [0, 2pi) before squaring
    a_reduced: assert property (@(posedge aclk)
        (cmd.mul_wb && cmd.sel == MUL_SQ) |-> (!x_reg[XW-1] && x_reg < TWO_PI_Q))
        else $error("angle not reduced before series");
    a_sum_range: assert property (@(posedge aclk)
        cmd.finish |-> (sum_reg <= MAG_MAX_S && sum_reg >= -MAG_MAX_S))
        else $error("series sum outside q8.40 range");
`endif

endmodule

>>> hw/rtl/sct_ctrl.sv
// sct_ctrl: sequencer for the sine/cosine unit; steps reduction, the
// shared multiplier and the series loop. depends on sct_pkg.
module sct_ctrl #(
    parameter int TERMS = sct_pkg::TERMS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output sct_pkg::dp_cmd_t      cmd,
    input  sct_pkg::dp_status_t   status
);
    import sct_pkg::*;

    localparam int IW = $clog2(TERMS);

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]       idx_reg, idx_next;
    mul_sel_t            phase_reg, phase_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_WRAP;
                end
            end
            S_WRAP: begin
                state_next = S_REDUCE;
                cnt_next   = STEP_W'(REDUCE_TOP);
            end
            S_REDUCE: begin
                if (cnt_reg == '0) begin
                    state_next = S_MSETUP;
                    phase_next = MUL_SQ;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_MSETUP: begin
                state_next = S_MSTEP;
                cnt_next   = '0;
            end
            S_MSTEP: begin
                if (cnt_reg == STEP_W'(PP_LAST)) begin
                    state_next = S_MWB;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MWB: begin
                case (phase_reg)
                    MUL_SQ: begin
                        state_next = S_ACCUM;
                        idx_next   = '0;
                    end
                    MUL_XSQ: begin
                        state_next = S_MSETUP;
                        phase_next = MUL_RECIP;
                    end
                    MUL_RECIP: begin
                        state_next = S_ACCUM;
                        idx_next   = idx_reg + 1'b1;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ACCUM: begin
                if (idx_reg == IW'(TERMS - 1)) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_MSETUP;
                    phase_next = MUL_XSQ;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.sel      = phase_reg;
        cmd.step     = cnt_reg;
        cmd.term_idx = RECIP_IDX_W'(idx_reg);
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_WRAP: begin
                cmd.wrap = status.x_neg;
            end
            S_REDUCE: begin
                cmd.reduce = 1'b1;
            end
            S_MSETUP: begin
                cmd.mul_setup = 1'b1;
            end
            S_MSTEP: begin
                cmd.mul_step = 1'b1;
            end
            S_MWB: begin
                cmd.mul_wb = 1'b1;
            end
            S_ACCUM: begin
                cmd.accum = 1'b1;
            end
            S_FINISH: begin
                cmd.finish = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            phase_reg     <= MUL_SQ;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_pp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MSTEP) |-> (cnt_reg <= STEP_W'(PP_LAST)))
        else $error("partial product index out of range");
    a_term_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ACCUM) |-> (idx_reg <= IW'(TERMS - 1)))
        else $error("term index past series length");
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid)
        else $error("finished result not presented");
`endif

endmodule

>>> hw/rtl/sine_cosine_taylor_unit.sv
// sine_cosine_taylor_unit: sine or cosine of a q7.24 angle by taylor series, q2.30 result.
// operation: one angle at a time, accepted only while idle; the series runs on the shared 24x24 multiplier,
// four partial products per 48-bit product, two products per series term.
// reset: aresetn synchronous active low, clears the sequencer and output valid only.
// depends on sct_pkg, sct_ctrl, sct_datapath.
module sine_cosine_taylor_unit #(
    parameter int TERMS = sct_pkg::TERMS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] value
);
    import sct_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sct_ctrl #(
        .TERMS (TERMS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    sct_datapath u_datapath (
        .aclk     (aclk),
        .cmd      (cmd),
        .status   (status),
        .in_kind  (s_tuser[0]),
        .in_angle (s_tdata),
        .value    (m_tdata)
    );

endmodule
